@@ rtl/core/ssd_pkg.sv @@
// Shared types, constants and the segment pattern table for the seven-segment serial driver.
package ssd_pkg;

  localparam int DigitCount   = 4;
  localparam int QueueDepth   = 2;
  localparam int SegBits      = 8;
  localparam int BitCntW      = $clog2(SegBits + 1);
  localparam int ThousandsPos = 3;
  localparam int TensPos      = 1;
  localparam int DotDigit     = 2;
  localparam int BlankLimit   = 1000;
  localparam int DotTensLimit = 5;
  localparam logic [SegBits-1:0] DotMask  = 8'h20;
  localparam logic [16:0]        Recip10  = 17'd52429;
  localparam int                 RecipSh  = 19;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REFRESH = 1'b1;

  typedef struct packed {
    logic [SegBits-1:0] seg;
    logic               sel;
  } ssd_cmd_t;

  function automatic logic [SegBits-1:0] seg_pattern(input logic [3:0] dec);
    logic [SegBits-1:0] pat;
    unique case (dec)
      4'd0:    pat = 8'h5f;
      4'd1:    pat = 8'h41;
      4'd2:    pat = 8'h9d;
      4'd3:    pat = 8'hcd;
      4'd4:    pat = 8'hc3;
      4'd5:    pat = 8'hce;
      4'd6:    pat = 8'hde;
      4'd7:    pat = 8'h45;
      4'd8:    pat = 8'hdf;
      4'd9:    pat = 8'hcf;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

@@ rtl/core/ssd_front.sv @@
// Front end: accepts beats, converts loaded values to segment bytes and queues refreshes.
module ssd_front #(
  parameter int DIGIT_COUNT = ssd_pkg::DigitCount
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             push,
  output logic             full,
  input  logic             mode_i,
  input  logic [15:0]      value_i,
  input  logic [1:0]       digit_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output ssd_pkg::ssd_cmd_t q_wdata_o
);

  localparam int Steps = (DIGIT_COUNT < 2) ? 2 : DIGIT_COUNT;
  localparam int StepW = $clog2(Steps);
  localparam int IdxW  = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic                        update_en_q;
  logic                        conv_busy_q, conv_busy_d;
  logic [StepW-1:0]            step_q, step_d;
  logic [15:0]                 rest_q, rest_d;
  logic                        blank_q, blank_d;
  logic                        dot_q, dot_d;
  logic [ssd_pkg::SegBits-1:0] seg_q [DIGIT_COUNT];
  logic [ssd_pkg::SegBits-1:0] seg_d [DIGIT_COUNT];

  logic                        accept;
  logic [32:0]                 prod;
  logic [15:0]                 quot;
  logic [15:0]                 quot_x10;
  logic [3:0]                  rem;
  logic [ssd_pkg::SegBits-1:0] conv_byte;
  logic [IdxW-1:0]             rd_idx;
  logic [ssd_pkg::SegBits-1:0] rd_byte;

  assign full   = conv_busy_q || q_full_i;
  assign accept = push && !full;

  assign prod     = rest_q * ssd_pkg::Recip10;
  assign quot     = 16'(prod >> ssd_pkg::RecipSh);
  assign quot_x10 = 16'(quot << 3) + 16'(quot << 1);
  assign rem      = 4'(rest_q - quot_x10);

  always_comb begin
    conv_byte = ssd_pkg::seg_pattern(rem);
    if ((32'(step_q) == ssd_pkg::ThousandsPos) && blank_q) begin
      conv_byte = '0;
    end
  end

  assign rd_idx = IdxW'(digit_i);

  always_comb begin
    rd_byte = (4'(digit_i) < 4'(DIGIT_COUNT)) ? seg_q[rd_idx] : '0;
    if ((32'(digit_i) == ssd_pkg::DotDigit) && dot_q) begin
      rd_byte = rd_byte | ssd_pkg::DotMask;
    end
  end

  assign q_push_o      = accept && (mode_i == ssd_pkg::MODE_REFRESH);
  assign q_wdata_o.seg = rd_byte;
  assign q_wdata_o.sel = (digit_i != 2'd0);

  always_comb begin
    conv_busy_d = conv_busy_q;
    step_d      = step_q;
    rest_d      = rest_q;
    blank_d     = blank_q;
    dot_d       = dot_q;
    seg_d       = seg_q;
    if (conv_busy_q) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        if (32'(step_q) == i) begin
          seg_d[i] = conv_byte;
        end
      end
      if (32'(step_q) == ssd_pkg::TensPos) begin
        dot_d = (32'(rem) < ssd_pkg::DotTensLimit);
      end
      rest_d = quot;
      if (step_q == StepW'(Steps - 1)) begin
        conv_busy_d = 1'b0;
      end else begin
        step_d = step_q + 1'b1;
      end
    end else if (accept && (mode_i == ssd_pkg::MODE_LOAD) && update_en_q) begin
      conv_busy_d = 1'b1;
      step_d      = '0;
      rest_d      = value_i;
      blank_d     = (32'(value_i) < ssd_pkg::BlankLimit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      update_en_q <= 1'b1;
      conv_busy_q <= 1'b0;
      step_q      <= '0;
      dot_q       <= 1'b1;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        seg_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        update_en_q <= cfg_wdata_i;
      end
      conv_busy_q <= conv_busy_d;
      step_q      <= step_d;
      dot_q       <= dot_d;
      seg_q       <= seg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q  <= rest_d;
    blank_q <= blank_d;
  end

endmodule

@@ rtl/core/ssd_fifo.sv @@
// Short command queue between the front end and the serialiser.
module ssd_fifo #(
  parameter int DEPTH = ssd_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ssd_pkg::ssd_cmd_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output ssd_pkg::ssd_cmd_t rdata_o,
  output logic              empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  ssd_pkg::ssd_cmd_t mem_q [DEPTH];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (32'(wptr_q) == DEPTH - 1) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (32'(rptr_q) == DEPTH - 1) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/core/ssd_back.sv @@
// Serialiser: shifts a segment byte out MSB first and follows it with the latch beat.
module ssd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  ssd_pkg::ssd_cmd_t q_rdata_i,
  output logic              q_pop_o,
  output logic              empty,
  input  logic              pop,
  output logic              data_bit_o,
  output logic              latch_o,
  output logic              last_o
);

  localparam logic [ssd_pkg::BitCntW-1:0] LatchStep = ssd_pkg::BitCntW'(ssd_pkg::SegBits);

  logic                            busy_q, busy_d;
  logic [ssd_pkg::SegBits-1:0]     shift_q, shift_d;
  logic [ssd_pkg::BitCntW-1:0]     cnt_q, cnt_d;
  logic                            sel_q, sel_d;
  logic                            taken;
  logic                            at_latch;

  assign at_latch   = (cnt_q == LatchStep);
  assign taken      = pop && busy_q;
  assign empty      = !busy_q;
  assign latch_o    = at_latch;
  assign last_o     = at_latch;
  assign data_bit_o = at_latch ? sel_q : shift_q[ssd_pkg::SegBits-1];

  always_comb begin
    busy_d  = busy_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    q_pop_o = 1'b0;
    if (taken) begin
      if (at_latch) begin
        busy_d = 1'b0;
      end else begin
        shift_d = shift_q << 1;
        cnt_d   = cnt_q + 1'b1;
      end
    end
    if ((!busy_q || (taken && at_latch)) && !q_empty_i) begin
      q_pop_o = 1'b1;
      busy_d  = 1'b1;
      shift_d = q_rdata_i.seg;
      sel_d   = q_rdata_i.sel;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    sel_q   <= sel_d;
  end

endmodule

@@ rtl/core/seven_segment_serial_driver.sv @@
// Top level of the seven-segment serial driver.
// A refresh beat produces nine result beats: eight segment bits MSB first, then the latch
// beat carrying the digit select bit; the serialiser delivers one result per cycle while
// pop stays high, and the command queue lets the input side accept further beats while
// results wait. A load beat, when updates are enabled, occupies the decimal converter,
// which produces one digit per cycle through a reciprocal multiply; full is high while
// the converter is busy.
module seven_segment_serial_driver #(
  parameter int DIGIT_COUNT = ssd_pkg::DigitCount,
  parameter int QUEUE_DEPTH = ssd_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic        mode_i,
  input  logic [15:0] value_i,
  input  logic [1:0]  digit_i,
  output logic        empty,
  input  logic        pop,
  output logic        data_bit_o,
  output logic        latch_o,
  output logic        last_o
);

  logic              q_full, q_push, q_empty, q_pop;
  ssd_pkg::ssd_cmd_t q_wdata, q_rdata;

  ssd_front #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .digit_i    (digit_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_wdata_o  (q_wdata)
  );

  ssd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  ssd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_rdata_i (q_rdata),
    .q_pop_o   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .data_bit_o(data_bit_o),
    .latch_o   (latch_o),
    .last_o    (last_o)
  );

  a_latch_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (latch_o == last_o))
    else $error("latch and last beats disagree");

  a_data_after_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && latch_o) |=> (empty || !latch_o))
    else $error("latch beat not followed by a data beat");

  a_hold_unpopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(latch_o) && $stable(data_bit_o)))
    else $error("waiting result changed before it was popped");

endmodule

@@ test/seven_segment_serial_driver_test.sv @@
// Self-checking testbench for the seven-segment serial driver with its own beat prediction.
`timescale 1ns / 100ps

module seven_segment_serial_driver_test;

  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles  = 8;
  localparam int HoldOffCycles = 300;
  localparam int MaxReports    = 40;
  localparam int DotModulus    = 100;
  localparam int DotLimit      = 50;
  localparam logic [79:0] SegCodes = {8'hcf, 8'hdf, 8'h45, 8'hde, 8'hce,
                                      8'hc3, 8'hcd, 8'h9d, 8'h41, 8'h5f};

  typedef struct packed {
    logic data_bit;
    logic latch;
    logic last;
  } shift_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        mode = ssd_pkg::MODE_LOAD;
  logic [15:0] value = '0;
  logic [1:0]  digit = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        data_bit;
  logic        latch;
  logic        last;

  shift_beat_t                 beats_due[$];
  logic [ssd_pkg::SegBits-1:0] shown_seg[ssd_pkg::DigitCount];
  logic [15:0]                 shown_value;
  logic                        update_en;
  int unsigned                 send_idle_pct;
  int unsigned                 pop_stall_pct;
  int unsigned                 hold_request;
  int unsigned                 err_count;

  seven_segment_serial_driver u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .push       (push),
    .full       (full),
    .mode_i     (mode),
    .value_i    (value),
    .digit_i    (digit),
    .empty      (empty),
    .pop        (pop),
    .data_bit_o (data_bit),
    .latch_o    (latch),
    .last_o     (last)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= MaxReports) begin
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  function automatic void model_load(input logic [15:0] v);
    int unsigned rest;
    if (!update_en) return;
    shown_value = v;
    rest = v;
    for (int i = 0; i < ssd_pkg::DigitCount; i++) begin
      shown_seg[i] = SegCodes[(rest % 10) * 8 +: 8];
      rest = rest / 10;
      if (i == ssd_pkg::ThousandsPos && v < ssd_pkg::BlankLimit) shown_seg[i] = '0;
    end
  endfunction

  function automatic void model_refresh(input logic [1:0] d);
    logic [ssd_pkg::SegBits-1:0] pattern;
    shift_beat_t                 b;
    pattern = (d < ssd_pkg::DigitCount) ? shown_seg[d] : '0;
    if (d == ssd_pkg::DotDigit && (shown_value % DotModulus) < DotLimit) begin
      pattern |= ssd_pkg::DotMask;
    end
    for (int k = ssd_pkg::SegBits - 1; k >= 0; k--) begin
      b = '{data_bit: pattern[k], latch: 1'b0, last: 1'b0};
      beats_due.push_back(b);
    end
    b = '{data_bit: (d != 0), latch: 1'b1, last: 1'b1};
    beats_due.push_back(b);
  endfunction

  task automatic send_beat(input logic m, input logic [15:0] v, input logic [1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push  <= 1'b1;
    mode  <= m;
    value <= v;
    digit <= d;
    do @(posedge clk_i); while (full);
    if (m == ssd_pkg::MODE_LOAD) model_load(v);
    else model_refresh(d);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_update_enable(input logic en);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk_i);
    update_en = en;
    cfg_we <= 1'b0;
  endtask

  task automatic refresh_all();
    for (int d = 0; d < ssd_pkg::DigitCount; d++) begin
      send_beat(ssd_pkg::MODE_REFRESH, 16'($urandom), d[1:0]);
    end
  endtask

  task automatic test_reset_blank();
    refresh_all();
  endtask

  task automatic test_display_values();
    send_beat(ssd_pkg::MODE_LOAD, 16'd999, 2'd0);
    send_beat(ssd_pkg::MODE_REFRESH, 16'hffff, 2'd3);
    send_beat(ssd_pkg::MODE_REFRESH, 16'h0000, 2'd2);
    send_beat(ssd_pkg::MODE_LOAD, 16'd1000, 2'd3);
    send_beat(ssd_pkg::MODE_REFRESH, 16'h0000, 2'd3);
    send_beat(ssd_pkg::MODE_REFRESH, 16'hffff, 2'd2);
    send_beat(ssd_pkg::MODE_LOAD, 16'hffff, 2'd3);
    refresh_all();
    send_beat(ssd_pkg::MODE_LOAD, 16'd12349, 2'd0);
    send_beat(ssd_pkg::MODE_REFRESH, 16'h0000, 2'd2);
    send_beat(ssd_pkg::MODE_LOAD, 16'd12350, 2'd0);
    send_beat(ssd_pkg::MODE_REFRESH, 16'h0000, 2'd2);
    send_beat(ssd_pkg::MODE_LOAD, 16'haaaa, 2'd0);
    send_beat(ssd_pkg::MODE_REFRESH, 16'h5555, 2'd1);
    send_beat(ssd_pkg::MODE_LOAD, 16'h0000, 2'd3);
    send_beat(ssd_pkg::MODE_REFRESH, 16'hffff, 2'd0);
  endtask

  task automatic test_update_enable();
    write_update_enable(1'b0);
    send_beat(ssd_pkg::MODE_LOAD, 16'd4321, 2'd0);
    refresh_all();
    write_update_enable(1'b1);
    send_beat(ssd_pkg::MODE_LOAD, 16'd4321, 2'd0);
    refresh_all();
  endtask

  task automatic test_backpressure();
    drain();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_request  = HoldOffCycles;
    for (int i = 0; i < 24; i++) begin
      if (i % 6 == 0) send_beat(ssd_pkg::MODE_LOAD, 16'($urandom), 2'd0);
      else send_beat(ssd_pkg::MODE_REFRESH, 16'h0000, 2'($urandom_range(3)));
    end
  endtask

  task automatic test_random_traffic(input int n_items, input int unsigned idle_pct,
                                     input int unsigned stall_pct, input logic en);
    int          done;
    logic [15:0] v;
    write_update_enable(en);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0:       v = 16'($urandom_range(1099));
          1:       v = 16'($urandom_range(654) * DotModulus + $urandom_range(45, 54));
          default: v = 16'($urandom);
        endcase
        send_beat(ssd_pkg::MODE_LOAD, v, 2'($urandom_range(3)));
        if (en) done++;
      end else begin
        send_beat(ssd_pkg::MODE_REFRESH, 16'($urandom), 2'($urandom_range(3)));
        done++;
      end
    end
  endtask

  initial begin : result_checker
    shift_beat_t want;
    int unsigned hold_left;
    hold_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (beats_due.size() == 0) begin
          report_mismatch("result beat with none expected", data_bit, 0);
        end else begin
          want = beats_due.pop_front();
          if (data_bit !== want.data_bit) report_mismatch("data_bit", data_bit, want.data_bit);
          if (latch !== want.latch) report_mismatch("latch", latch, want.latch);
          if (last !== want.last) report_mismatch("last", last, want.last);
        end
      end
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_n);
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < ssd_pkg::DigitCount; i++) shown_seg[i] = '0;
    shown_value   = '0;
    update_en     = 1'b1;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_request  = 0;
    err_count     = 0;
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_reset_blank();
    test_display_values();
    test_update_enable();
    test_backpressure();
    test_random_traffic(93, 0, 0, 1'b1);
    test_random_traffic(93, 52, 0, 1'b1);
    test_random_traffic(93, 0, 52, 1'b0);
    test_random_traffic(93, 10, 10, 1'b1);
    drain();
    if (err_count == 0 && beats_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ seven_segment_serial_driver.f @@
rtl/core/ssd_pkg.sv
rtl/core/ssd_front.sv
rtl/core/ssd_fifo.sv
rtl/core/ssd_back.sv
rtl/core/seven_segment_serial_driver.sv
test/seven_segment_serial_driver_test.sv
